@@ sv/hall_pkg.sv @@
package hall_pkg;

    localparam int POSITION_BITS_DEF = 23;
    localparam int FIELD_W           = 23;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

    localparam logic [FIELD_W-1:0] MAX_BYTES_RESET = FIELD_W'(5242880);
    localparam logic [FIELD_W-1:0] CNT_MAX         = '1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CASE  = 8'h20;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;

    localparam logic KIND_LINK    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [6:0] {
        ST_TEXT        = 7'b0000001,
        ST_TAG_OPEN    = 7'b0000010,
        ST_TAG_NAME    = 7'b0000100,
        ST_ATTR_NAME   = 7'b0001000,
        ST_VALUE_START = 7'b0010000,
        ST_VALUE       = 7'b0100000,
        ST_TAG_CLOSE   = 7'b1000000
    } parse_state_t;

    typedef struct packed {
        logic               kind;
        logic [FIELD_W-1:0] link_start;
        logic [FIELD_W-1:0] link_length;
        logic [FIELD_W-1:0] tags_seen;
        logic [FIELD_W-1:0] links_seen;
        logic               final_res;
    } result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

@@ sv/html_anchor_link_locator_core.sv @@
// Output: an accepted byte within max_bytes updates the parser at once; its results
// (none, one or two) are written into the result queue and offered on the m_ side,
// one result per cycle while m_tready is high. Throughput: one byte per cycle; s_tready
// drops while the four-entry result queue has fewer than two free entries.
// Reset: synchronous, active low; clears the parser, the counters and the result queue,
// and loads max_bytes with 5242880. The byte marked by s_tlast also clears the parser.
module html_anchor_link_locator_core
    import hall_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [FIELD_W-1:0] cfg_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // byte_in
    input  logic               s_tlast,   // end_of_doc
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [95:0]        m_tdata,   // link_start, link_length, tags_seen, links_seen
    output logic               m_tuser,   // kind
    output logic               m_tlast    // final_res
);

    localparam int PW = POSITION_BITS;
    localparam int CW = (PW > FIELD_W) ? PW : FIELD_W;

    logic [FIELD_W-1:0] max_bytes_reg;

    parse_state_t       state_reg, state_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic               closing_reg, closing_next;
    logic [PW-1:0]      tag_start_reg, tag_start_next;
    logic [7:0]         tag_char_reg, tag_char_next;
    logic [PW-1:0]      attr_start_reg, attr_start_next;
    logic [31:0]        attr_chars_reg, attr_chars_next;
    logic               attr_href_reg, attr_href_next;
    logic [7:0]         quote_reg, quote_next;
    logic [PW-1:0]      value_start_reg, value_start_next;
    logic [7:0]         value_char_reg, value_char_next;
    logic               in_anchor_reg, in_anchor_next;
    logic [PW-1:0]      href_start_reg, href_start_next;
    logic [PW-1:0]      href_len_reg, href_len_next;
    logic [7:0]         href_char_reg, href_char_next;
    logic [FIELD_W-1:0] tag_count_reg, tag_count_next;
    logic [FIELD_W-1:0] link_count_reg, link_count_next;

    result_t            queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    logic               accept, pop, in_range, single_a, do_open, do_close, link_emit, ends;
    logic [7:0]         c;
    logic [PW-1:0]      off;
    logic [1:0]         push_n;
    result_t            res0, res1, head;

    assign c         = s_tdata;
    assign cfg_ready = 1'b1;
    assign s_tready  = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign accept    = s_tvalid && s_tready;
    assign pop       = m_tvalid && m_tready;
    assign in_range  = (CW'(pos_reg) < CW'(max_bytes_reg)) && (pos_reg != '1);
    assign single_a  = ((pos_reg - tag_start_reg) == PW'(1)) && ((tag_char_reg | CH_CASE) == CH_A);
    assign off       = pos_reg - attr_start_reg;

    always_comb begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        closing_next     = closing_reg;
        tag_start_next   = tag_start_reg;
        tag_char_next    = tag_char_reg;
        attr_start_next  = attr_start_reg;
        attr_chars_next  = attr_chars_reg;
        attr_href_next   = attr_href_reg;
        quote_next       = quote_reg;
        value_start_next = value_start_reg;
        value_char_next  = value_char_reg;
        in_anchor_next   = in_anchor_reg;
        href_start_next  = href_start_reg;
        href_len_next    = href_len_reg;
        href_char_next   = href_char_reg;
        tag_count_next   = tag_count_reg;
        link_count_next  = link_count_reg;
        do_open          = 1'b0;
        do_close         = 1'b0;
        link_emit        = 1'b0;
        ends             = (quote_reg == CH_SPACE) ? (is_space(c) || c == CH_GT) : (c == quote_reg);

        if (accept && in_range) begin
            pos_next = pos_reg + PW'(1);
            unique case (state_reg)
                ST_TEXT: begin
                    if (c == CH_LT) begin
                        state_next   = ST_TAG_OPEN;
                        closing_next = 1'b0;
                    end
                end
                ST_TAG_OPEN: begin
                    if (c == CH_SLASH) begin
                        closing_next = 1'b1;
                    end else if (is_letter(c)) begin
                        state_next     = ST_TAG_NAME;
                        tag_start_next = pos_reg;
                        tag_char_next  = c;
                    end else if (c == CH_GT) begin
                        state_next = ST_TEXT;
                    end
                end
                ST_TAG_NAME: begin
                    if (is_space(c)) begin
                        if (closing_reg) begin
                            do_close   = 1'b1;
                            state_next = ST_TAG_CLOSE;
                        end else begin
                            do_open         = 1'b1;
                            state_next      = ST_ATTR_NAME;
                            attr_start_next = '0;
                        end
                    end else if (c == CH_GT) begin
                        do_close   = closing_reg;
                        do_open    = !closing_reg;
                        state_next = ST_TEXT;
                    end else if (c == CH_SLASH) begin
                        do_open    = 1'b1;
                        state_next = ST_TAG_CLOSE;
                    end
                end
                ST_ATTR_NAME: begin
                    if (is_space(c) || c == CH_EQ) begin
                        if (attr_start_reg != '0) begin
                            attr_href_next = (off == PW'(4))
                                && ((attr_chars_reg[7:0] | CH_CASE) == CH_H)
                                && ((attr_chars_reg[15:8] | CH_CASE) == CH_R)
                                && ((attr_chars_reg[23:16] | CH_CASE) == CH_E)
                                && ((attr_chars_reg[31:24] | CH_CASE) == CH_F);
                            state_next      = ST_VALUE_START;
                            attr_start_next = '0;
                        end
                    end else if (c == CH_GT) begin
                        state_next      = ST_TEXT;
                        attr_start_next = '0;
                    end else if (attr_start_reg == '0) begin
                        if (is_letter(c)) begin
                            attr_start_next = pos_reg;
                            attr_chars_next = {24'd0, c};
                        end
                    end else if (off < PW'(4)) begin
                        attr_chars_next[{off[1:0], 3'b000} +: 8] =
                            attr_chars_reg[{off[1:0], 3'b000} +: 8] | c;
                    end
                end
                ST_VALUE_START: begin
                    if (c == CH_DQ || c == CH_SQ) begin
                        quote_next       = c;
                        value_start_next = pos_reg + PW'(1);
                        state_next       = ST_VALUE;
                    end else if (c == CH_GT) begin
                        state_next       = ST_TEXT;
                        attr_start_next  = '0;
                        value_start_next = '0;
                    end else if (!is_space(c)) begin
                        quote_next       = CH_SPACE;
                        value_start_next = pos_reg;
                        value_char_next  = c;
                        state_next       = ST_VALUE;
                    end
                end
                ST_VALUE: begin
                    if (!ends) begin
                        if (pos_reg == value_start_reg) begin
                            value_char_next = c;
                        end
                    end else begin
                        if (in_anchor_reg && attr_href_reg) begin
                            href_start_next = value_start_reg;
                            href_len_next   = pos_reg - value_start_reg;
                            href_char_next  = value_char_reg;
                        end
                        attr_start_next  = '0;
                        value_start_next = '0;
                        quote_next       = '0;
                        state_next       = (c == CH_GT) ? ST_TEXT : ST_ATTR_NAME;
                    end
                end
                ST_TAG_CLOSE: begin
                    if (c == CH_GT) begin
                        state_next = ST_TEXT;
                    end
                end
                default: begin
                    state_next = ST_TEXT;
                end
            endcase

            if (do_open) begin
                if (tag_count_reg != CNT_MAX) begin
                    tag_count_next = tag_count_reg + FIELD_W'(1);
                end
                if (single_a) begin
                    in_anchor_next = 1'b1;
                    href_len_next  = '0;
                end
            end
            if (do_close && in_anchor_reg && single_a) begin
                in_anchor_next = 1'b0;
                if (href_len_reg != '0) begin
                    if (!(href_len_reg == PW'(1) && href_char_reg == CH_HASH)) begin
                        link_emit = 1'b1;
                        if (link_count_reg != CNT_MAX) begin
                            link_count_next = link_count_reg + FIELD_W'(1);
                        end
                    end
                    href_len_next = '0;
                end
            end
        end
    end

    always_comb begin
        res1.kind        = KIND_SUMMARY;
        res1.link_start  = '0;
        res1.link_length = '0;
        res1.tags_seen   = tag_count_next;
        res1.links_seen  = link_count_next;
        res1.final_res   = 1'b1;
        if (link_emit) begin
            res0.kind        = KIND_LINK;
            res0.link_start  = FIELD_W'(href_start_reg);
            res0.link_length = FIELD_W'(href_len_reg);
            res0.tags_seen   = '0;
            res0.links_seen  = '0;
            res0.final_res   = !s_tlast;
        end else begin
            res0 = res1;
        end
        push_n = (accept && s_tlast) ? (link_emit ? 2'd2 : 2'd1) : {1'b0, link_emit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= MAX_BYTES_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_bytes_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_tlast)) begin
            state_reg       <= ST_TEXT;
            pos_reg         <= '0;
            closing_reg     <= 1'b0;
            tag_start_reg   <= '0;
            tag_char_reg    <= '0;
            attr_start_reg  <= '0;
            attr_chars_reg  <= '0;
            attr_href_reg   <= 1'b0;
            quote_reg       <= '0;
            value_start_reg <= '0;
            value_char_reg  <= '0;
            in_anchor_reg   <= 1'b0;
            href_start_reg  <= '0;
            href_len_reg    <= '0;
            href_char_reg   <= '0;
            tag_count_reg   <= '0;
            link_count_reg  <= '0;
        end else begin
            state_reg       <= state_next;
            pos_reg         <= pos_next;
            closing_reg     <= closing_next;
            tag_start_reg   <= tag_start_next;
            tag_char_reg    <= tag_char_next;
            attr_start_reg  <= attr_start_next;
            attr_chars_reg  <= attr_chars_next;
            attr_href_reg   <= attr_href_next;
            quote_reg       <= quote_next;
            value_start_reg <= value_start_next;
            value_char_reg  <= value_char_next;
            in_anchor_reg   <= in_anchor_next;
            href_start_reg  <= href_start_next;
            href_len_reg    <= href_len_next;
            href_char_reg   <= href_char_next;
            tag_count_reg   <= tag_count_next;
            link_count_reg  <= link_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2) begin
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(pop);
            count_reg  <= count_reg + QCNT_W'(push_n) - QCNT_W'(pop);
        end
    end

    assign head     = queue_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tuser  = head.kind;
    assign m_tlast  = head.final_res;
    assign m_tdata  = {4'd0, head.links_seen, head.tags_seen, head.link_length, head.link_start};

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_SUMMARY) |-> m_tlast)
        else $error("summary result not marked final");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_LINK) |-> (head.tags_seen == '0 && head.links_seen == '0))
        else $error("link result carries counts");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (pos_reg == '0 && state_reg == ST_TEXT && !in_anchor_reg))
        else $error("parser not cleared after document end");

endmodule

@@ tb/html_anchor_link_locator_core_test.sv @@
`timescale 1ns / 1ps

module html_anchor_link_locator_core_test;
    import hall_pkg::*;

    localparam int          STALL_LIMIT  = 4000;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [7:0]  CH_TAB       = 8'h09;
    localparam logic [7:0]  CH_CR        = 8'h0D;
    localparam logic [7:0]  CH_Z         = 8'h7A;
    localparam logic [7:0]  CH_X         = 8'h78;
    localparam logic [FIELD_W-1:0] POS_FULL  = '1;
    localparam logic [FIELD_W-1:0] LIMIT_TOP = '1;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [FIELD_W-1:0] cfg_data  = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = '0;
    logic               s_tlast   = 1'b0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [95:0]        m_tdata;
    logic               m_tuser;
    logic               m_tlast;

    html_anchor_link_locator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #2 aclk = ~aclk;

    int          errors      = 0;
    int          idle_cycles = 0;
    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    rx_mode_t    rx_mode     = RX_OPEN;
    int unsigned rx_left     = 0;
    logic [7:0]  rx_cycle    = '0;

    logic [7:0] doc_bytes[$];
    result_t    byte_results[$];
    result_t    pending_results[$];

    logic [FIELD_W-1:0] byte_limit;
    parse_state_t       tok_state;
    logic [FIELD_W-1:0] doc_pos;
    logic               closing_tag;
    logic [FIELD_W-1:0] name_start;
    logic [7:0]         name_first;
    logic [FIELD_W-1:0] attr_start;
    logic [31:0]        attr_chars;
    logic               attr_href;
    logic [7:0]         quote_ch;
    logic [FIELD_W-1:0] val_start;
    logic [7:0]         val_first;
    logic               anchor_open;
    logic [FIELD_W-1:0] href_pos;
    logic [FIELD_W-1:0] href_len;
    logic [7:0]         href_first;
    logic [FIELD_W-1:0] tag_total;
    logic [FIELD_W-1:0] link_total;

    function automatic logic is_ws(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | CH_CASE;
        return folded >= CH_A && folded <= CH_Z;
    endfunction

    function automatic logic single_a(input logic [FIELD_W-1:0] pos);
        return (pos - name_start) == 1 && (name_first | CH_CASE) == CH_A;
    endfunction

    task automatic add_byte(input logic [7:0] c);
        doc_bytes.insert(doc_bytes.size(), c);
    endtask

    task automatic clear_doc();
        tok_state   = ST_TEXT;
        doc_pos     = '0;
        closing_tag = 1'b0;
        name_start  = '0;
        name_first  = '0;
        attr_start  = '0;
        attr_chars  = '0;
        attr_href   = 1'b0;
        quote_ch    = '0;
        val_start   = '0;
        val_first   = '0;
        anchor_open = 1'b0;
        href_pos    = '0;
        href_len    = '0;
        href_first  = '0;
        tag_total   = '0;
        link_total  = '0;
    endtask

    task automatic note_tag_open(input logic [FIELD_W-1:0] pos);
        if (tag_total != CNT_MAX) tag_total++;
        if (single_a(pos)) begin
            anchor_open = 1'b1;
            href_len    = '0;
        end
    endtask

    task automatic note_tag_close(input logic [FIELD_W-1:0] pos);
        result_t r;
        if (anchor_open && single_a(pos)) begin
            anchor_open = 1'b0;
            if (href_len != 0) begin
                if (!(href_len == 1 && href_first == CH_HASH)) begin
                    r             = '0;
                    r.kind        = KIND_LINK;
                    r.link_start  = href_pos;
                    r.link_length = href_len;
                    byte_results.insert(byte_results.size(), r);
                    if (link_total != CNT_MAX) link_total++;
                end
                href_len = '0;
            end
        end
    endtask

    task automatic note_attr_name(input logic [FIELD_W-1:0] pos);
        attr_href = (pos - attr_start) == 4 &&
                    (attr_chars[7:0] | CH_CASE) == CH_H &&
                    (attr_chars[15:8] | CH_CASE) == CH_R &&
                    (attr_chars[23:16] | CH_CASE) == CH_E &&
                    (attr_chars[31:24] | CH_CASE) == CH_F;
        tok_state  = ST_VALUE_START;
        attr_start = '0;
    endtask

    // Advances the tokenizer by one byte and queues the links and summary it produces.
    task automatic predict_byte(input logic [7:0] c, input logic last);
        logic [FIELD_W-1:0] pos;
        logic [FIELD_W-1:0] off;
        logic               ends;
        result_t            r;
        byte_results.delete();
        if (doc_pos < byte_limit && doc_pos != POS_FULL) begin
            pos = doc_pos;
            case (tok_state)
                ST_TEXT: begin
                    if (c == CH_LT) begin
                        tok_state   = ST_TAG_OPEN;
                        closing_tag = 1'b0;
                    end
                end
                ST_TAG_OPEN: begin
                    if (c == CH_SLASH) begin
                        closing_tag = 1'b1;
                    end else if (is_alpha(c)) begin
                        tok_state  = ST_TAG_NAME;
                        name_start = pos;
                        name_first = c;
                    end else if (c == CH_GT) begin
                        tok_state = ST_TEXT;
                    end
                end
                ST_TAG_NAME: begin
                    if (is_ws(c)) begin
                        if (closing_tag) begin
                            note_tag_close(pos);
                            tok_state = ST_TAG_CLOSE;
                        end else begin
                            note_tag_open(pos);
                            tok_state  = ST_ATTR_NAME;
                            attr_start = '0;
                        end
                    end else if (c == CH_GT) begin
                        if (closing_tag) note_tag_close(pos);
                        else note_tag_open(pos);
                        tok_state = ST_TEXT;
                    end else if (c == CH_SLASH) begin
                        note_tag_open(pos);
                        tok_state = ST_TAG_CLOSE;
                    end
                end
                ST_ATTR_NAME: begin
                    if (is_ws(c) || c == CH_EQ) begin
                        if (attr_start != 0) note_attr_name(pos);
                    end else if (c == CH_GT) begin
                        tok_state  = ST_TEXT;
                        attr_start = '0;
                    end else if (attr_start == 0) begin
                        if (is_alpha(c)) begin
                            attr_start = pos;
                            attr_chars = {24'd0, c};
                        end
                    end else begin
                        off = pos - attr_start;
                        if (off < 4) attr_chars = attr_chars | ({24'd0, c} << (8 * off));
                    end
                end
                ST_VALUE_START: begin
                    if (c == CH_DQ || c == CH_SQ) begin
                        quote_ch  = c;
                        val_start = pos + FIELD_W'(1);
                        tok_state = ST_VALUE;
                    end else if (c == CH_GT) begin
                        tok_state  = ST_TEXT;
                        attr_start = '0;
                        val_start  = '0;
                    end else if (!is_ws(c)) begin
                        quote_ch  = CH_SPACE;
                        val_start = pos;
                        val_first = c;
                        tok_state = ST_VALUE;
                    end
                end
                ST_VALUE: begin
                    ends = (quote_ch == CH_SPACE) ? (is_ws(c) || c == CH_GT) : (c == quote_ch);
                    if (!ends) begin
                        if (pos == val_start) val_first = c;
                    end else begin
                        if (anchor_open && attr_href) begin
                            href_pos   = val_start;
                            href_len   = pos - val_start;
                            href_first = val_first;
                        end
                        attr_start = '0;
                        val_start  = '0;
                        quote_ch   = '0;
                        tok_state  = (c == CH_GT) ? ST_TEXT : ST_ATTR_NAME;
                    end
                end
                ST_TAG_CLOSE: begin
                    if (c == CH_GT) tok_state = ST_TEXT;
                end
                default: begin
                    tok_state = ST_TEXT;
                end
            endcase
            doc_pos = pos + FIELD_W'(1);
        end
        if (last) begin
            r            = '0;
            r.kind       = KIND_SUMMARY;
            r.tags_seen  = tag_total;
            r.links_seen = link_total;
            byte_results.insert(byte_results.size(), r);
            clear_doc();
        end
        if (byte_results.size() != 0) byte_results[byte_results.size() - 1].final_res = 1'b1;
        foreach (byte_results[i]) pending_results.insert(pending_results.size(), byte_results[i]);
    endtask

    task automatic send_byte(input logic [7:0] c, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                burst_left = $urandom_range(30, 120);
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 8);
                gap        = $urandom_range(1, 6);
            end
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        predict_byte(c, last);
    endtask

    task automatic send_doc();
        for (int i = 0; i < doc_bytes.size(); i++) begin
            send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
        end
    endtask

    task automatic write_max_bytes(input logic [FIELD_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        byte_limit = value;
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic add_cased(input string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if ($urandom_range(0, 1) == 1) c = c & ~CH_CASE;
            add_byte(c);
        end
    endtask

    function automatic logic [7:0] ws_byte();
        logic [7:0] c;
        if ($urandom_range(0, 2) == 0) c = 8'($urandom_range(CH_TAB, CH_CR));
        else c = CH_SPACE;
        return c;
    endfunction

    function automatic logic [7:0] value_byte(input logic [7:0] quote);
        logic [7:0] c;
        c = 8'($urandom_range(8'h21, 8'h7E));
        if (c == quote || c == CH_GT || c == CH_LT) c = CH_X;
        return c;
    endfunction

    task automatic add_text(input int unsigned n);
        logic [7:0] c;
        repeat (n) begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_LT) c = ws_byte();
            add_byte(c);
        end
    endtask

    task automatic add_quoted(input logic [7:0] quote, input int unsigned n);
        logic [7:0] c;
        add_byte(quote);
        repeat (n) begin
            if ($urandom_range(0, 7) == 0) begin
                c = 8'($urandom_range(0, 255));
                if (c == quote) c = CH_X;
            end else begin
                c = value_byte(quote);
            end
            add_byte(c);
        end
        add_byte(quote);
    endtask

    task automatic add_attr();
        add_byte(ws_byte());
        case ($urandom_range(0, 9))
            6:       add_cased("hre");
            7:       add_cased("hrefx");
            8:       add_cased("id");
            9:       add_cased("x");
            default: add_cased("href");
        endcase
        case ($urandom_range(0, 4))
            3: begin
                add_byte(ws_byte());
                add_byte(CH_EQ);
                add_byte(ws_byte());
            end
            4:       add_byte(ws_byte());
            default: add_byte(CH_EQ);
        endcase
        case ($urandom_range(0, 6))
            0, 1: add_quoted(CH_DQ, $urandom_range(0, 6));
            2:    add_quoted(CH_SQ, $urandom_range(0, 6));
            3: begin
                repeat ($urandom_range(1, 5)) add_byte(value_byte(CH_SPACE));
            end
            4: begin
                if ($urandom_range(0, 1) == 1) begin
                    add_byte(CH_HASH);
                end else begin
                    add_byte(CH_DQ);
                    add_byte(CH_HASH);
                    add_byte(CH_DQ);
                end
            end
            5: add_quoted($urandom_range(0, 1) ? CH_DQ : CH_SQ, 0);
            default: ;
        endcase
    endtask

    task automatic add_tag(input logic anchor, input logic closing);
        add_byte(CH_LT);
        if (closing) add_byte(CH_SLASH);
        if (anchor) begin
            add_byte($urandom_range(0, 1) ? CH_A : (CH_A & ~CH_CASE));
        end else begin
            case ($urandom_range(0, 4))
                0:       add_cased("b");
                1:       add_cased("ab");
                2:       add_cased("div");
                3:       add_cased("p");
                default: add_cased("aa");
            endcase
        end
        if (!closing) repeat ($urandom_range(0, anchor ? 3 : 2)) add_attr();
        case ($urandom_range(0, 7))
            0: begin
                add_byte(ws_byte());
                add_byte(CH_GT);
            end
            1: begin
                add_byte(CH_SLASH);
                add_byte(CH_GT);
            end
            default: add_byte(CH_GT);
        endcase
    endtask

    // Mostly well-formed anchors with random attributes, mixed with stray syntax.
    task automatic build_random_doc();
        doc_bytes.delete();
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    add_tag(1'b1, 1'b0);
                    add_text($urandom_range(0, 4));
                    add_tag(1'b1, 1'b1);
                end
                4: add_tag(1'b1, 1'b0);
                5: add_tag(1'b1, 1'b1);
                6: add_tag(1'b0, 1'($urandom_range(0, 1)));
                7: add_text($urandom_range(1, 6));
                8: begin
                    repeat ($urandom_range(1, 6)) begin
                        case ($urandom_range(0, 7))
                            0:       add_byte(CH_LT);
                            1:       add_byte(CH_GT);
                            2:       add_byte(CH_SLASH);
                            3:       add_byte(CH_EQ);
                            4:       add_byte(CH_DQ);
                            5:       add_byte(CH_SQ);
                            6:       add_byte(CH_HASH);
                            default: add_byte(8'($urandom_range(0, 255)));
                        endcase
                    end
                end
                default: begin
                    add_tag(1'b1, 1'b0);
                    add_tag(1'b0, 1'b0);
                    add_tag(1'b1, 1'b1);
                end
            endcase
        end
    endtask

    task automatic send_random_docs(input int unsigned count);
        int unsigned first;
        first = items_sent;
        while (items_sent - first < count) begin
            build_random_doc();
            send_doc();
        end
    endtask

    task automatic test_directed_cases();
        doc_bytes.delete();
        add_str("</a><a href=#><b HREF=u></A>");
        send_doc();
        doc_bytes.delete();
        add_byte(8'hFF);
        send_doc();
    endtask

    task automatic test_limit_one_byte();
        write_max_bytes(FIELD_W'(1));
        doc_bytes.delete();
        add_str("<a href=v></a>");
        send_doc();
        send_random_docs(30);
    endtask

    task automatic test_limit_full();
        write_max_bytes(LIMIT_TOP);
        send_random_docs(300);
    endtask

    task automatic test_limit_short();
        repeat (4) begin
            write_max_bytes(FIELD_W'($urandom_range(2, 40)));
            send_random_docs(70);
        end
    endtask

    task automatic test_limit_default();
        write_max_bytes(MAX_BYTES_RESET);
        send_random_docs(300);
    endtask

    task automatic check_field(input string what, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result expected none actual tuser %0h tdata %0h tlast %0h",
                         $time, m_tuser, m_tdata, m_tlast);
            end else begin
                want = pending_results.pop_front();
                check_field("kind", FIELD_W'(want.kind), FIELD_W'(m_tuser));
                check_field("link_start", want.link_start, m_tdata[0 +: FIELD_W]);
                check_field("link_length", want.link_length, m_tdata[FIELD_W +: FIELD_W]);
                check_field("tags_seen", want.tags_seen, m_tdata[2*FIELD_W +: FIELD_W]);
                check_field("links_seen", want.links_seen, m_tdata[3*FIELD_W +: FIELD_W]);
                check_field("tdata padding", '0, FIELD_W'(m_tdata[95:4*FIELD_W]));
                check_field("final_res", FIELD_W'(want.final_res), FIELD_W'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 8'd1;
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 96);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:  m_tready <= 1'b1;
            RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
            default:  m_tready <= (rx_cycle[2:0] != 3'd0);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("html_anchor_link_locator_core_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        byte_limit = MAX_BYTES_RESET;
        clear_doc();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_limit_one_byte();
        test_limit_full();
        test_limit_short();
        test_limit_default();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (errors == 0) begin
            $display("html_anchor_link_locator_core_test: clean");
        end else begin
            $display("html_anchor_link_locator_core_test: errors");
        end
        $finish;
    end

endmodule
